// ===== design/pfc_pkg.sv =====
`timescale 1ns / 1ps
// pfc_pkg: format codes, configuration indexes and channel types
// for the pixel format converter; no dependencies

package pfc_pkg;

    localparam int PIXEL_W = 32;
    localparam int BYTES_W = 3;
    localparam int FMT_W   = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic [FMT_W-1:0]     fmt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [PIXEL_W-1:0]   pixel_t;
    typedef logic [BYTES_W-1:0]   nbytes_t;

    localparam fmt_t FMT_RGBA8   = 3'd0;
    localparam fmt_t FMT_RGBA4   = 3'd1;
    localparam fmt_t FMT_RGB5_A1 = 3'd2;
    localparam fmt_t FMT_RGB565  = 3'd3;
    localparam fmt_t FMT_LA8     = 3'd4;
    localparam fmt_t FMT_L8      = 3'd5;

    localparam cfg_idx_t CFG_SRC_FORMAT = 1'b0;
    localparam cfg_idx_t CFG_DST_FORMAT = 1'b1;

    localparam nbytes_t NBYTES_4 = 3'd4;
    localparam nbytes_t NBYTES_2 = 3'd2;
    localparam nbytes_t NBYTES_1 = 3'd1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

endpackage

// ===== design/pixel_format_converter.sv =====
`timescale 1ns / 1ps
// pixel_format_converter: top level, input register, expand and pack logic,
// result register; depends on pfc_pkg, pfc_expand and pfc_pack
// throughput: one pixel per cycle while m_ready does not stall, set by the two-stage register pipeline
// reset: synchronous active-low aresetn empties both stages and sets
// both format registers to rgba8

module pixel_format_converter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  pfc_pkg::cfg_idx_t cfg_index,
    input  pfc_pkg::fmt_t     cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfc_pkg::pixel_t   s_src_pixel,
    input  logic              s_last_in,
    output logic              m_valid,
    input  logic              m_ready,
    output pfc_pkg::pixel_t   m_dst_pixel,
    output pfc_pkg::nbytes_t  m_dst_bytes,
    output logic              m_last_out
);
    import pfc_pkg::*;

    fmt_t    src_format_reg;
    fmt_t    dst_format_reg;

    logic    in_valid_reg;
    logic    in_valid_next;
    pixel_t  in_pixel_reg;
    logic    in_last_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    pixel_t  out_pixel_reg;
    nbytes_t out_bytes_reg;
    logic    out_last_reg;

    logic    out_load;
    rgba_t   rgba;
    pixel_t  pack_pixel;
    nbytes_t pack_bytes;

    // format registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_format_reg <= FMT_RGBA8;
            dst_format_reg <= FMT_RGBA8;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SRC_FORMAT: src_format_reg <= cfg_wdata;
                CFG_DST_FORMAT: dst_format_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pixel_reg <= s_src_pixel;
            in_last_reg  <= s_last_in;
        end
    end

    pfc_expand u_expand (
        .src_format (src_format_reg),
        .src_pixel  (in_pixel_reg),
        .rgba       (rgba)
    );

    pfc_pack u_pack (
        .dst_format (dst_format_reg),
        .rgba       (rgba),
        .dst_pixel  (pack_pixel),
        .dst_bytes  (pack_bytes)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_pixel_reg <= pack_pixel;
            out_bytes_reg <= pack_bytes;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_dst_pixel = out_pixel_reg;
    assign m_dst_bytes = out_bytes_reg;
    assign m_last_out  = out_last_reg;

endmodule

// ===== design/pfc_expand.sv =====
`timescale 1ns / 1ps
// pfc_expand: unpacks one source pixel into rgba8 channels
// depends on pfc_pkg

module pfc_expand (
    input  pfc_pkg::fmt_t   src_format,
    input  pfc_pkg::pixel_t src_pixel,
    output pfc_pkg::rgba_t  rgba
);
    import pfc_pkg::*;

    logic [15:0] h;

    assign h = src_pixel[15:0];

    always_comb begin
        rgba = '0;
        case (src_format)
            FMT_RGBA8: begin
                rgba.r = src_pixel[7:0];
                rgba.g = src_pixel[15:8];
                rgba.b = src_pixel[23:16];
                rgba.a = src_pixel[31:24];
            end
            FMT_RGBA4: begin
                rgba.r = {h[15:12], 4'b0};
                rgba.g = {h[11:8], 4'b0};
                rgba.b = {h[7:4], 4'b0};
                rgba.a = {h[3:0], 4'b0};
            end
            FMT_RGB5_A1: begin
                rgba.r = {h[15:11], 3'b0};
                rgba.g = {h[10:6], 3'b0};
                rgba.b = {h[5:1], 3'b0};
                rgba.a = {8{h[0]}};
            end
            FMT_RGB565: begin
                rgba.r = {h[15:11], 3'b0};
                rgba.g = {h[10:5], 2'b0};
                rgba.b = {h[4:0], 3'b0};
                rgba.a = 8'hff;
            end
            FMT_LA8: begin
                rgba.r = src_pixel[7:0];
                rgba.g = src_pixel[7:0];
                rgba.b = src_pixel[7:0];
                rgba.a = src_pixel[15:8];
            end
            FMT_L8: begin
                rgba.r = src_pixel[7:0];
                rgba.g = src_pixel[7:0];
                rgba.b = src_pixel[7:0];
                rgba.a = 8'hff;
            end
            default: begin
                rgba = '0;
            end
        endcase
    end

endmodule

// ===== design/pfc_pack.sv =====
`timescale 1ns / 1ps
// pfc_pack: packs rgba8 channels into the destination format,
// including the luminance average; depends on pfc_pkg

module pfc_pack (
    input  pfc_pkg::fmt_t    dst_format,
    input  pfc_pkg::rgba_t   rgba,
    output pfc_pkg::pixel_t  dst_pixel,
    output pfc_pkg::nbytes_t dst_bytes
);
    import pfc_pkg::*;

    localparam logic [10:0] RECIP3 = 11'd683;

    logic [9:0]  lum_sum;
    logic [20:0] lum_prod;
    logic [7:0]  lum;

    // divide by 3 via reciprocal, exact for sums up to 765
    assign lum_sum  = 10'(rgba.r) + 10'(rgba.g) + 10'(rgba.b);
    assign lum_prod = 21'(lum_sum) * 21'(RECIP3);
    assign lum      = lum_prod[18:11];

    always_comb begin
        dst_pixel = '0;
        dst_bytes = NBYTES_4;
        case (dst_format)
            FMT_RGBA4: begin
                dst_pixel = {16'b0, rgba.r[7:4], rgba.g[7:4], rgba.b[7:4], rgba.a[7:4]};
                dst_bytes = NBYTES_2;
            end
            FMT_RGB5_A1: begin
                dst_pixel = {16'b0, rgba.r[7:3], rgba.g[7:3], rgba.b[7:3], rgba.a[7]};
                dst_bytes = NBYTES_2;
            end
            FMT_RGB565: begin
                dst_pixel = {16'b0, rgba.r[7:3], rgba.g[7:2], rgba.b[7:3]};
                dst_bytes = NBYTES_2;
            end
            FMT_LA8: begin
                dst_pixel = {16'b0, rgba.a, lum};
                dst_bytes = NBYTES_2;
            end
            FMT_L8: begin
                dst_pixel = {24'b0, lum};
                dst_bytes = NBYTES_1;
            end
            default: begin
                dst_pixel = {rgba.a, rgba.b, rgba.g, rgba.r};
                dst_bytes = NBYTES_4;
            end
        endcase
    end

endmodule
